/* design/lfu_replacement_policy_top_defines.svh */
// Assertion macros used by the LFU replacement policy top level.
`ifndef LFU_REPLACEMENT_POLICY_TOP_DEFINES_SVH
`define LFU_REPLACEMENT_POLICY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LFU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lfu_pkg.sv */
// Shared types, widths and codes for the LFU replacement policy.
package lfu_pkg;

    localparam int SLOTS     = 16;
    localparam int FREQ_BITS = 8;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RANK_W    = SLOT_W;
    localparam int SLOT_IN_W = 4;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam int TOTAL_W   = 32;

    localparam logic [FREQ_BITS-1:0] FREQ_MAX  = {FREQ_BITS{1'b1}};
    localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(SLOTS - 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACCESS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EVICT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

    // rank update modes for the update pass
    localparam logic [1:0] MODE_INC_ALL = 2'd0;
    localparam logic [1:0] MODE_INC_LT  = 2'd1;
    localparam logic [1:0] MODE_DEC_GT  = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [FREQ_BITS-1:0] freq;
        logic [RANK_W-1:0]    rank;
    } lfu_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        lfu_entry_t        data;
    } lfu_wr_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [RANK_W-1:0] rank;
    } lfu_best_t;

endpackage

/* design/lfu_table.sv */
// Per-slot state: valid bits, use frequencies and recency ranks.
module lfu_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clr,
    input  lfu_pkg::lfu_wr_t   wr,
    input  logic [lfu_pkg::SLOT_W-1:0] rd_addr,
    output lfu_pkg::lfu_entry_t rd_data
);
    import lfu_pkg::*;

    logic [SLOTS-1:0]     valid_reg;
    logic [FREQ_BITS-1:0] freq_reg [SLOTS];
    logic [RANK_W-1:0]    rank_reg [SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= wr.data.valid;
        end
    end

    // payload, no reset: only read behind a valid bit
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            freq_reg[wr.addr] <= wr.data.freq;
            rank_reg[wr.addr] <= wr.data.rank;
        end
    end

    assign rd_data.valid = valid_reg[rd_addr];
    assign rd_data.freq  = freq_reg[rd_addr];
    assign rd_data.rank  = rank_reg[rd_addr];

endmodule

/* design/lfu_cmp.sv */
// Eviction compare unit: keeps the lowest-frequency, oldest valid slot seen.
module lfu_cmp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr,
    input  logic                        en,
    input  logic [lfu_pkg::SLOT_W-1:0]  cand_idx,
    input  lfu_pkg::lfu_entry_t         cand,
    output lfu_pkg::lfu_best_t          best
);
    import lfu_pkg::*;

    logic                 found_reg, found_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [FREQ_BITS-1:0] freq_reg, freq_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic                 better;

    // lower frequency wins; equal frequency goes to the older rank
    assign better = cand.valid &&
                    (!found_reg || (cand.freq < freq_reg) ||
                     ((cand.freq == freq_reg) && (cand.rank > rank_reg)));

    always_comb
    begin
        found_next = found_reg;
        idx_next   = idx_reg;
        freq_next  = freq_reg;
        rank_next  = rank_reg;
        if (clr)
        begin
            found_next = 1'b0;
        end
        else if (en && better)
        begin
            found_next = 1'b1;
            idx_next   = cand_idx;
            freq_next  = cand.freq;
            rank_next  = cand.rank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        freq_reg <= freq_next;
        rank_reg <= rank_next;
    end

    assign best.found = found_reg;
    assign best.idx   = idx_reg;
    assign best.rank  = rank_reg;

endmodule

/* design/lfu_replacement_policy_top.sv */
// Top level of the LFU replacement policy: command sequencer and result port.
//
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+------------------------------------
// command  | in  | start & !busy     | cmd[2:0], slot[3:0]
// result   | out | done (1 cycle)    | status[1:0], victim_slot[3:0],
//          |     |                   | eviction_total[31:0]
//
// A transaction is taken on a clock edge with start high and busy low.
// Busy states per command, set by the single read port of the slot table
// walked one slot a cycle (SLOTS = 16):
//   insert into a free slot, access or remove hit: load, rank pass, finish;
//   miss, duplicate, clear, unknown: load only; evict on an empty set: load,
//   scan, select; evict: load, scan, select, rank pass, finish.
// The result shows in the cycle in which busy falls, with done high for exactly
// one cycle; a new command may be taken in that same cycle.
// The receiver cannot stall the result. Reset (rst_n low, async) empties
// all slots and zeroes the eviction count.
`include "lfu_replacement_policy_top_defines.svh"

module lfu_replacement_policy_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfu_pkg::CMD_W-1:0]     cmd,
    input  logic [lfu_pkg::SLOT_IN_W-1:0] slot,
    output logic                          busy,
    output logic                          done,
    output logic [lfu_pkg::STAT_W-1:0]    status,
    output logic [lfu_pkg::SLOT_IN_W-1:0] victim_slot,
    output logic [lfu_pkg::TOTAL_W-1:0]   eviction_total
);
    import lfu_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;  // read the command's slot
    localparam logic [2:0] ST_SCAN  = 3'd2;  // evict: find the victim
    localparam logic [2:0] ST_EVSEL = 3'd3;  // evict: take the scan result
    localparam logic [2:0] ST_PASS  = 3'd4;  // rank update over all slots
    localparam logic [2:0] ST_FIN   = 3'd5;  // write the target slot

    logic [2:0]           state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [SLOT_IN_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [1:0]           mode_reg, mode_next;
    logic [SLOT_W-1:0]    target_reg, target_next;
    logic [RANK_W-1:0]    old_rank_reg, old_rank_next;
    logic [FREQ_BITS-1:0] tgt_freq_reg, tgt_freq_next;
    logic [TOTAL_W-1:0]   counter_reg, counter_next;
    logic                 done_reg, done_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [SLOT_IN_W-1:0] victim_reg, victim_next;

    logic [SLOT_W-1:0]    rd_addr;
    lfu_entry_t           rd_data;
    lfu_wr_t              wr;
    logic                 tbl_clr;
    logic                 cmp_clr;
    logic                 cmp_en;
    lfu_best_t            best;
    logic                 in_range;
    logic                 hit;
    logic                 accept;
    logic                 adjust;
    logic [RANK_W-1:0]    new_rank;
    logic [FREQ_BITS-1:0] freq_bump;

    assign accept   = start && !busy;
    assign in_range = 32'(slot_reg) < 32'(SLOTS);
    assign hit      = in_range && rd_data.valid;
    // one table read port: the command's slot during load, the walk otherwise
    assign rd_addr  = (state_reg == ST_LOAD) ? SLOT_W'(slot_reg) : idx_reg;

    // rank move for the slot under the walk
    always_comb
    begin
        adjust   = 1'b0;
        new_rank = rd_data.rank;
        case (mode_reg)
            MODE_INC_ALL:
            begin
                adjust   = 1'b1;
                new_rank = rd_data.rank + RANK_W'(1);
            end
            MODE_INC_LT:
            begin
                adjust   = rd_data.rank < old_rank_reg;
                new_rank = rd_data.rank + RANK_W'(1);
            end
            MODE_DEC_GT:
            begin
                adjust   = rd_data.rank > old_rank_reg;
                new_rank = rd_data.rank - RANK_W'(1);
            end
            default:
            begin
                adjust = 1'b0;
            end
        endcase
    end

    assign freq_bump = (tgt_freq_reg == FREQ_MAX) ? tgt_freq_reg
                                                  : tgt_freq_reg + FREQ_BITS'(1);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        idx_next      = idx_reg;
        mode_next     = mode_reg;
        target_next   = target_reg;
        old_rank_next = old_rank_reg;
        tgt_freq_next = tgt_freq_reg;
        counter_next  = counter_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        victim_next   = victim_reg;
        tbl_clr       = 1'b0;
        cmp_clr       = 1'b0;
        cmp_en        = 1'b0;
        wr            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    slot_next  = slot;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmp_clr       = 1'b1;
                idx_next      = '0;
                target_next   = SLOT_W'(slot_reg);
                old_rank_next = rd_data.rank;
                tgt_freq_next = rd_data.freq;
                status_next   = STAT_OK;
                victim_next   = '0;
                unique case (cmd_reg) inside
                    CMD_INSERT:
                    begin
                        if (!in_range || rd_data.valid)
                        begin
                            status_next = in_range ? STAT_PRESENT : STAT_MISSING;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            mode_next  = MODE_INC_ALL;
                            state_next = ST_PASS;
                        end
                    end
                    CMD_ACCESS, CMD_REMOVE:
                    begin
                        if (!hit)
                        begin
                            status_next = STAT_MISSING;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            mode_next  = (cmd_reg == CMD_ACCESS) ? MODE_INC_LT
                                                                 : MODE_DEC_GT;
                            state_next = ST_PASS;
                        end
                    end
                    CMD_EVICT:
                    begin
                        state_next = ST_SCAN;
                    end
                    CMD_CLEAR:
                    begin
                        tbl_clr      = 1'b1;
                        counter_next = '0;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmp_en   = 1'b1;
                idx_next = idx_reg + SLOT_W'(1);
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = ST_EVSEL;
                end
            end
            ST_EVSEL:
            begin
                if (!best.found)
                begin
                    status_next = STAT_EMPTY;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    target_next   = best.idx;
                    old_rank_next = best.rank;
                    mode_next     = MODE_DEC_GT;
                    state_next    = ST_PASS;
                end
            end
            ST_PASS:
            begin
                wr.en        = rd_data.valid && (idx_reg != target_reg) && adjust;
                wr.addr      = idx_reg;
                wr.data      = rd_data;
                wr.data.rank = new_rank;
                idx_next     = idx_reg + SLOT_W'(1);
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                wr.en      = 1'b1;
                wr.addr    = target_reg;
                wr.data    = '0;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        wr.data.valid = 1'b1;
                        wr.data.freq  = FREQ_BITS'(1);
                    end
                    CMD_ACCESS:
                    begin
                        wr.data.valid = 1'b1;
                        wr.data.freq  = freq_bump;
                    end
                    CMD_EVICT:
                    begin
                        counter_next = counter_reg + TOTAL_W'(1);
                        victim_next  = SLOT_IN_W'(target_reg);
                    end
                    default:
                    begin
                        wr.data.valid = 1'b0;
                    end
                endcase
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            counter_reg <= '0;
            done_reg    <= 1'b0;
            status_reg  <= STAT_OK;
            victim_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            counter_reg <= counter_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            victim_reg  <= victim_next;
        end
    end

    // command payload and per-transaction scratch
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        mode_reg     <= mode_next;
        target_reg   <= target_next;
        old_rank_reg <= old_rank_next;
        tgt_freq_reg <= tgt_freq_next;
    end

    lfu_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (tbl_clr),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfu_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (cmp_clr),
        .en       (cmp_en),
        .cand_idx (idx_reg),
        .cand     (rd_data),
        .best     (best)
    );

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign victim_slot    = victim_reg;
    assign eviction_total = counter_reg;

    // result strobe only ever lands with the sequencer back at idle
    `LFU_ASSERT_IMP(a_done_idle, done_reg, state_reg == ST_IDLE, "result while busy")
    // strobe lasts one cycle
    `LFU_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "result strobe longer than one cycle")
    // a taken command always starts with the slot read
    `LFU_ASSERT_NXT(a_accept_load, accept, state_reg == ST_LOAD, "command not loaded")
    // only a successful evict reports a victim
    `LFU_ASSERT_IMP(a_victim_ok, done_reg && (status_reg != STAT_OK), victim_reg == '0,
                    "victim reported on a failed command")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the LFU replacement policy: random and directed commands.
`timescale 1ns / 100ps

module tb;
    import lfu_pkg::*;

    // Sender gaps and the longest busy stretch (evict) are far shorter than
    // WATCHDOG_CYCLES, so that long without any transaction means a hang.
    localparam int WATCHDOG_CYCLES = 1000;
    localparam int SETTLE_CYCLES   = 40;      // longest busy stretch plus margin
    localparam int RANDOM_ITEMS    = 1530;
    localparam int HOT_ITEMS       = 400;     // enough accesses to pin a slot at FREQ_MAX
    localparam int MAX_REPORTS     = 10;
    localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};  // highest code, unknown

    // Random-phase mixes
    localparam int MIX_EVEN  = 0;
    localparam int MIX_FILL  = 1;
    localparam int MIX_DRAIN = 2;

    typedef logic [CMD_W-1:0] cmd_code_t;

    typedef struct {
        logic [CMD_W-1:0]     op;
        logic [SLOT_IN_W-1:0] slot;
        int unsigned          gap;    // idle cycles after this transaction
    } cmd_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [SLOT_IN_W-1:0] victim;
        logic [TOTAL_W-1:0]   total;
    } lfu_result_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [CMD_W-1:0]     cmd   = '0;
    logic [SLOT_IN_W-1:0] slot  = '0;
    logic                 busy;
    logic                 done;
    logic [STAT_W-1:0]    status;
    logic [SLOT_IN_W-1:0] victim_slot;
    logic [TOTAL_W-1:0]   eviction_total;

    lfu_replacement_policy_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cmd            (cmd),
        .slot           (slot),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .victim_slot    (victim_slot),
        .eviction_total (eviction_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Shadow copy of the slot table
    //------------------------------------------------------------------
    bit                   slot_live [SLOTS];
    logic [FREQ_BITS-1:0] slot_freq [SLOTS];
    logic [RANK_W-1:0]    slot_rank [SLOTS];
    logic [TOTAL_W-1:0]   evict_count;

    // coverage tallies for the closing summary
    int op_seen [8];
    int sat_hits, dup_hits, miss_hits, empty_hits;

    cmd_item_t   pending_cmds[$];
    lfu_result_t expected_results[$];

    int  planned_cnt  = 0;
    int  accepted_cnt = 0;
    int  errors       = 0;
    int  quiet_cycles = 0;
    bit  took         = 1'b0;   // command transaction at the last rising edge
    int  calm_left    = 0;      // remaining back-to-back items in a no-gap run

    function automatic void wipe_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_freq[i] = '0;
            slot_rank[i] = '0;
        end
        evict_count = '0;
    endfunction

    // Slot becomes most recent; everything newer than it ages by one.
    function automatic void promote(input int s);
        int prior;
        prior = slot_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && i != s && slot_rank[i] < prior)
                slot_rank[i]++;
        slot_rank[s] = '0;
    endfunction

    // Slot leaves; everything older than it moves up by one.
    function automatic void retire(input int s);
        int prior;
        prior = slot_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && i != s && slot_rank[i] > prior)
                slot_rank[i]--;
        slot_live[s] = 1'b0;
        slot_freq[s] = '0;
        slot_rank[s] = '0;
    endfunction

    function automatic lfu_result_t apply_command(input logic [CMD_W-1:0] op,
                                                  input logic [SLOT_IN_W-1:0] s);
        lfu_result_t r;
        int          best;
        bit          found;
        int          live_cnt;
        r.status = STAT_OK;
        r.victim = '0;
        op_seen[op]++;
        case (op)
            CMD_INSERT:
            begin
                if (s >= SLOTS)
                    r.status = STAT_MISSING;
                else if (slot_live[s])
                    r.status = STAT_PRESENT;
                else
                begin
                    // new slot starts as the oldest, then gets touched
                    live_cnt = 0;
                    for (int i = 0; i < SLOTS; i++)
                        live_cnt += slot_live[i];
                    slot_rank[s] = RANK_W'(live_cnt);
                    slot_live[s] = 1'b1;
                    slot_freq[s] = FREQ_BITS'(1);
                    promote(s);
                end
            end
            CMD_ACCESS:
            begin
                if (s >= SLOTS || !slot_live[s])
                    r.status = STAT_MISSING;
                else
                begin
                    if (slot_freq[s] == FREQ_MAX)
                        sat_hits++;
                    else
                        slot_freq[s]++;
                    promote(s);
                end
            end
            CMD_REMOVE:
            begin
                if (s >= SLOTS || !slot_live[s])
                    r.status = STAT_MISSING;
                else
                    retire(s);
            end
            CMD_EVICT:
            begin
                found = 1'b0;
                best  = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && (!found || slot_freq[i] < slot_freq[best] ||
                        (slot_freq[i] == slot_freq[best] && slot_rank[i] > slot_rank[best])))
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                if (!found)
                    r.status = STAT_EMPTY;
                else
                begin
                    retire(best);
                    evict_count++;
                    r.victim = SLOT_IN_W'(best);
                end
            end
            CMD_CLEAR:
                wipe_table();
            default: ;  // unknown codes leave the table alone
        endcase
        r.total = evict_count;
        case (r.status)
            STAT_PRESENT: dup_hits++;
            STAT_MISSING: miss_hits++;
            STAT_EMPTY:   empty_hits++;
            default: ;
        endcase
        return r;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int unsigned draw_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic void queue_cmd(input logic [CMD_W-1:0] op,
                                      input logic [SLOT_IN_W-1:0] s);
        cmd_item_t it;
        it.op   = op;
        it.slot = s;
        it.gap  = draw_gap();
        pending_cmds.push_back(it);
        planned_cnt++;
    endfunction

    function automatic logic [CMD_W-1:0] pick_op(input int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                if (r < 45) return CMD_INSERT;
                if (r < 85) return CMD_ACCESS;
                if (r < 90) return CMD_REMOVE;
                if (r < 98) return CMD_EVICT;
                if (r < 99) return CMD_CLEAR;
            end
            MIX_DRAIN:
            begin
                if (r < 15) return CMD_INSERT;
                if (r < 30) return CMD_ACCESS;
                if (r < 55) return CMD_REMOVE;
                if (r < 95) return CMD_EVICT;
                if (r < 98) return CMD_CLEAR;
            end
            default:
            begin
                if (r < 30) return CMD_INSERT;
                if (r < 60) return CMD_ACCESS;
                if (r < 72) return CMD_REMOVE;
                if (r < 92) return CMD_EVICT;
                if (r < 95) return CMD_CLEAR;
            end
        endcase
        return cmd_code_t'($urandom_range(CMD_CLEAR + 1, CMD_TOP));
    endfunction

    //------------------------------------------------------------------
    // Driver: presents one command transaction at a time. Inputs move on
    // the falling edge; a raised start is held until busy lets it through.
    // While idle, cmd and slot carry junk that the block must ignore.
    //------------------------------------------------------------------
    int unsigned idle_left = 0;
    cmd_item_t   cur_item;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !took)
            begin
                // still waiting for the block to take it
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
                cmd   <= cmd_code_t'($urandom);
                slot  <= SLOT_IN_W'($urandom);
            end
            else if (pending_cmds.size() != 0)
            begin
                cur_item  = pending_cmds.pop_front();
                idle_left = cur_item.gap;
                start <= 1'b1;
                cmd   <= cur_item.op;
                slot  <= cur_item.slot;
            end
            else
                start <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Monitor: on each rising edge, predict any command taken and check
    // any result strobed. The prediction is queued before the check so a
    // result can never overtake its own command.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        lfu_result_t want;
        if (!rst_n)
            took = 1'b0;
        else
        begin
            took = start && !busy;
            if (took)
            begin
                expected_results.push_back(apply_command(cmd, slot));
                accepted_cnt++;
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("[%0t] unexpected result: status=%0d victim=%0d total=%0d",
                                 $realtime, status, victim_slot, eviction_total);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || victim_slot !== want.victim ||
                        eviction_total !== want.total)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"[%0t] mismatch: status exp %0d got %0d, ",
                                      "victim exp %0d got %0d, total exp %0d got %0d"},
                                     $realtime, want.status, status, want.victim,
                                     victim_slot, want.total, eviction_total);
                    end
                end
            end
            // watchdog: any transaction on either side resets the count
            if (took || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Timeout after %0d idle cycles, %0d of %0d commands taken",
                         quiet_cycles, accepted_cnt, planned_cnt);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial
    begin : run
        int hot;
        int mix;
        int round_len;
        int r;

        wipe_table();

        // Directed: empty set, misses, duplicates, LFU pick, LRU tie-break,
        // unknown codes and clear.
        queue_cmd(CMD_EVICT,  4'd0);    // nothing to evict
        queue_cmd(CMD_ACCESS, 4'd0);    // missing key
        queue_cmd(CMD_REMOVE, 4'd15);   // missing key
        queue_cmd(CMD_INSERT, 4'd0);
        queue_cmd(CMD_INSERT, 4'd15);
        queue_cmd(CMD_INSERT, 4'd0);    // duplicate
        queue_cmd(CMD_ACCESS, 4'd15);
        queue_cmd(CMD_EVICT,  4'd9);    // lowest frequency wins: slot 0
        queue_cmd(CMD_INSERT, 4'd7);
        queue_cmd(CMD_INSERT, 4'd3);
        queue_cmd(CMD_ACCESS, 4'd15);
        queue_cmd(CMD_EVICT,  4'd0);    // tie at freq 1, older slot 7 goes
        queue_cmd(CMD_ACCESS, 4'd3);
        queue_cmd(CMD_REMOVE, 4'd15);
        queue_cmd(CMD_REMOVE, 4'd3);
        queue_cmd(CMD_EVICT,  4'd15);   // empty again
        queue_cmd(cmd_code_t'(CMD_CLEAR + 1), 4'd5);
        queue_cmd(cmd_code_t'(CMD_CLEAR + 2), 4'd10);
        queue_cmd(CMD_TOP,    4'd15);
        queue_cmd(CMD_INSERT, 4'd1);
        queue_cmd(CMD_INSERT, 4'd2);
        queue_cmd(CMD_EVICT,  4'd0);
        queue_cmd(CMD_CLEAR,  4'd6);    // also zeroes the eviction count
        queue_cmd(CMD_ACCESS, 4'd2);
        queue_cmd(CMD_EVICT,  4'd0);

        // Hot slot: hammer one key past frequency saturation while a few
        // cold keys come and go around it.
        hot = $urandom_range(0, SLOTS - 1);
        queue_cmd(CMD_INSERT, SLOT_IN_W'(hot));
        repeat (HOT_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 88)
                queue_cmd(CMD_ACCESS, SLOT_IN_W'(hot));
            else if (r < 94)
                queue_cmd(CMD_INSERT, SLOT_IN_W'($urandom));
            else if (r < 97)
                queue_cmd(CMD_ACCESS, SLOT_IN_W'($urandom));
            else
                queue_cmd(CMD_EVICT, SLOT_IN_W'($urandom));
        end

        // Random rounds, each with its own mix so the table both fills up
        // and drains down to empty.
        while (planned_cnt < RANDOM_ITEMS + HOT_ITEMS + 26)
        begin
            mix       = $urandom_range(MIX_EVEN, MIX_DRAIN);
            round_len = $urandom_range(40, 120);
            repeat (round_len)
                queue_cmd(pick_op(mix), SLOT_IN_W'($urandom));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < planned_cnt || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        errors += expected_results.size();

        $display("Covered %0d cmds: ins %0d, acc %0d, rem %0d, evict %0d, clr %0d, unknown %0d",
                 accepted_cnt, op_seen[CMD_INSERT], op_seen[CMD_ACCESS], op_seen[CMD_REMOVE],
                 op_seen[CMD_EVICT], op_seen[CMD_CLEAR],
                 op_seen[CMD_CLEAR + 1] + op_seen[CMD_CLEAR + 2] + op_seen[CMD_TOP]);
        $display("Evicted %0d since clear; empty %0d, dup %0d, miss %0d, saturated %0d",
                 evict_count, empty_hits, dup_hits, miss_hits, sat_hits);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
